### rtl/core/rbi_pkg.sv
package rbi_pkg;

   localparam int COORD_WIDTH_DEF   = 24;
   localparam int ANGLE_WIDTH_DEF   = 16;
   localparam int CORDIC_STAGES_DEF = 16;

   // binary angle accumulator, 2^32 per turn
   localparam int ACC_W = 32;
   localparam logic [ACC_W-1:0] ACC_HALF_TURN = 32'h8000_0000;

   // scaling of the inclination vector
   localparam int NORM_MAX_SHIFT = 29;
   localparam int NORM_SQ_TOP    = 60;
   localparam int NORM_Z_TOP     = 30;
   // CORDIC input normalization target, 2^30
   localparam int NORM_ANGLE_TOP = 30;

   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_REF_X = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_REF_Y = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_REF_Z = 2'd2;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [ACC_W-1:0] atan_entry(input int unsigned idx);
      logic [ACC_W-1:0] val;
      case (idx)
         0:       val = 32'h2000_0000;
         1:       val = 32'h12E4_051E;
         2:       val = 32'h09FB_385B;
         3:       val = 32'h0511_11D4;
         4:       val = 32'h028B_0D43;
         5:       val = 32'h0145_D7E1;
         6:       val = 32'h00A2_F61E;
         7:       val = 32'h0051_7C55;
         8:       val = 32'h0028_BE53;
         9:       val = 32'h0014_5F2F;
         10:      val = 32'h000A_2F98;
         11:      val = 32'h0005_17CC;
         12:      val = 32'h0002_8BE6;
         13:      val = 32'h0001_45F3;
         14:      val = 32'h0000_A2F9;
         15:      val = 32'h0000_517C;
         16:      val = 32'h0000_28BE;
         17:      val = 32'h0000_145F;
         18:      val = 32'h0000_0A2F;
         19:      val = 32'h0000_0517;
         20:      val = 32'h0000_028B;
         21:      val = 32'h0000_0145;
         22:      val = 32'h0000_00A2;
         23:      val = 32'h0000_0051;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

### rtl/core/rbi_if.sv
interface rbi_req_if import rbi_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] target_x;
   logic signed [COORD_WIDTH-1:0] target_y;
   logic signed [COORD_WIDTH-1:0] target_z;

   modport source (output valid, output target_x, output target_y, output target_z,
                   input ready);
   modport sink   (input valid, input target_x, input target_y, input target_z,
                   output ready);
endinterface

interface rbi_rsp_if import rbi_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic [COORD_WIDTH:0]          range_3d;
   logic [COORD_WIDTH:0]          range_xy;
   logic signed [ANGLE_WIDTH-1:0] bearing;
   logic signed [ANGLE_WIDTH-1:0] inclination;

   modport source (output valid, output range_3d, output range_xy, output bearing,
                   output inclination, input ready);
   modport sink   (input valid, input range_3d, input range_xy, input bearing,
                   input inclination, output ready);
endinterface

interface rbi_csr_if import rbi_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic [CSR_ADDR_W-1:0]         index;
   logic signed [COORD_WIDTH-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/rbi_delay.sv
module rbi_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (enable) begin
         line_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign dout = line_ff[DEPTH-1];

endmodule

### rtl/core/rbi_isqrt.sv
module rbi_isqrt #(
   parameter int IN_W = 62
) (
   input  logic              clock,
   input  logic              enable,
   input  logic [IN_W-1:0]   radicand,
   output logic [IN_W/2-1:0] root
);

   localparam int ROOT_W = IN_W / 2;
   localparam int RW     = ROOT_W + 3;

   logic [RW-1:0]     rem_ff  [ROOT_W];
   logic [RW-1:0]     rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];
   logic [IN_W-1:0]   rad_ff  [ROOT_W];
   logic [IN_W-1:0]   rad_in  [ROOT_W];

   // one result bit per stage: bring down two radicand bits, try root*4+1
   always_comb begin
      logic [RW-1:0]     rem_p;
      logic [RW-1:0]     cur;
      logic [RW-1:0]     trial;
      logic [ROOT_W-1:0] root_p;
      logic [IN_W-1:0]   rad_p;
      logic              take;
      for (int s = 0; s < ROOT_W; s++) begin
         if (s == 0) begin
            rem_p  = '0;
            root_p = '0;
            rad_p  = radicand;
         end else begin
            rem_p  = rem_ff[s-1];
            root_p = root_ff[s-1];
            rad_p  = rad_ff[s-1];
         end
         cur        = {rem_p[RW-3:0], rad_p[IN_W-1 -: 2]};
         trial      = RW'({root_p, 2'b01});
         take       = (cur >= trial);
         rem_in[s]  = take ? (cur - trial) : cur;
         root_in[s] = {root_p[ROOT_W-2:0], take};
         rad_in[s]  = {rad_p[IN_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int s = 0; s < ROOT_W; s++) begin
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
            rad_ff[s]  <= rad_in[s];
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

### rtl/core/rbi_cordic.sv
module rbi_cordic import rbi_pkg::*; #(
   parameter int IN_W        = 32,
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
   parameter int STAGES      = CORDIC_STAGES_DEF
) (
   input  logic                   clock,
   input  logic                   enable,
   input  logic signed [IN_W-1:0] vec_y,
   input  logic signed [IN_W-1:0] vec_x,
   output logic [ANGLE_WIDTH-1:0] angle
);

   localparam int EXT_W = IN_W + 1;
   localparam int DW    = ((IN_W > NORM_ANGLE_TOP + 1) ? IN_W : NORM_ANGLE_TOP + 1) + 4;
   localparam int SH_W  = $clog2(NORM_ANGLE_TOP + 2);

   // fold into the right half plane
   logic signed [EXT_W-1:0] xa_ff, ya_ff, xa_in, ya_in;
   logic                    nega_ff, zeroa_ff;
   // normalization shift
   logic signed [EXT_W-1:0] xb_ff, yb_ff;
   logic [SH_W-1:0]         shb_ff, shb_in;
   logic                    negb_ff, zerob_ff;
   // scaled start vector
   logic signed [DW-1:0]    xc_ff, yc_ff;
   logic [ACC_W-1:0]        accc_ff;
   logic                    zeroc_ff;
   // rotations
   logic signed [DW-1:0]    x_ff [STAGES];
   logic signed [DW-1:0]    x_in [STAGES];
   logic signed [DW-1:0]    y_ff [STAGES];
   logic signed [DW-1:0]    y_in [STAGES];
   logic [ACC_W-1:0]        acc_ff [STAGES];
   logic [ACC_W-1:0]        acc_in [STAGES];
   logic                    zero_ff [STAGES];
   logic [ANGLE_WIDTH-1:0]  ang_ff, ang_in;

   always_comb begin
      logic signed [EXT_W-1:0] xe, ye;
      xe    = EXT_W'(vec_x);
      ye    = EXT_W'(vec_y);
      xa_in = vec_x[IN_W-1] ? -xe : xe;
      ya_in = vec_x[IN_W-1] ? -ye : ye;
   end

   always_comb begin
      logic [EXT_W-1:0] mx, my, m;
      mx     = xa_ff;
      my     = ya_ff[EXT_W-1] ? EXT_W'(-ya_ff) : EXT_W'(ya_ff);
      m      = (mx > my) ? mx : my;
      shb_in = '0;
      for (int i = 0; i <= NORM_ANGLE_TOP; i++) begin
         if ((m >> (NORM_ANGLE_TOP - i)) == '0) begin
            shb_in = SH_W'(i + 1);
         end
      end
   end

   always_comb begin
      logic signed [DW-1:0] xp, yp, xs, ys;
      logic [ACC_W-1:0]     ap;
      for (int s = 0; s < STAGES; s++) begin
         if (s == 0) begin
            xp = xc_ff;
            yp = yc_ff;
            ap = accc_ff;
         end else begin
            xp = x_ff[s-1];
            yp = y_ff[s-1];
            ap = acc_ff[s-1];
         end
         xs = xp >>> s;
         ys = yp >>> s;
         // rotate toward the x axis; y at zero takes the negative turn
         if (!yp[DW-1] && (yp != '0)) begin
            x_in[s]   = xp + ys;
            y_in[s]   = yp - xs;
            acc_in[s] = ap + atan_entry(s);
         end else begin
            x_in[s]   = xp - ys;
            y_in[s]   = yp + xs;
            acc_in[s] = ap - atan_entry(s);
         end
      end
   end

   always_comb begin
      logic [ACC_W-1:0] rnd;
      rnd    = acc_ff[STAGES-1] + (ACC_W'(1) << (ACC_W - 1 - ANGLE_WIDTH));
      ang_in = zero_ff[STAGES-1] ? '0 : rnd[ACC_W-1 -: ANGLE_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         xa_ff    <= xa_in;
         ya_ff    <= ya_in;
         nega_ff  <= vec_x[IN_W-1];
         zeroa_ff <= (vec_x == '0) && (vec_y == '0);
         xb_ff    <= xa_ff;
         yb_ff    <= ya_ff;
         shb_ff   <= shb_in;
         negb_ff  <= nega_ff;
         zerob_ff <= zeroa_ff;
         xc_ff    <= DW'(xb_ff) <<< shb_ff;
         yc_ff    <= DW'(yb_ff) <<< shb_ff;
         accc_ff  <= negb_ff ? ACC_HALF_TURN : '0;
         zeroc_ff <= zerob_ff;
         for (int s = 0; s < STAGES; s++) begin
            x_ff[s]    <= x_in[s];
            y_ff[s]    <= y_in[s];
            acc_ff[s]  <= acc_in[s];
            zero_ff[s] <= (s == 0) ? zeroc_ff : zero_ff[(s == 0) ? 0 : s - 1];
         end
         ang_ff <= ang_in;
      end
   end

   assign angle = ang_ff;

endmodule

### rtl/core/range_bearing_inclination_core.sv
// Range, bearing and inclination of a target point against a reference point.
// Channels: req_bus takes one target point (target_x/y/z) per valid/ready
// request; rsp_bus returns range_3d, range_xy, bearing and inclination for it,
// in order; csr_bus writes ref_x (index 0), ref_y (1), ref_z (2), always ready.
// Angles are binary angles, pi/2^(ANGLE_WIDTH-1) per LSB.
// Throughput: one request per cycle while rsp_bus is not stalled; fully pipelined.
// The bit-serial square root yields one root bit per stage (ISQ_W/2 bits, 31 at
// the defaults). The square root stages set the depth; the CORDIC stages follow
// them.
// Reset clears the reference point to zero and drops all requests in flight.
// When the receiver stalls, the finished result holds in the output register;
// the pipeline keeps taking requests while its last stage is empty, then holds
// all stages (req_bus.ready low) until the output register is taken.
module range_bearing_inclination_core import rbi_pkg::*; #(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input logic       clock,
   input logic       reset,
   rbi_req_if.sink   req_bus,
   rbi_rsp_if.source rsp_bus,
   rbi_csr_if.sink   csr_bus
);

   localparam int D_W     = COORD_WIDTH + 1;
   localparam int SQ_W    = 2 * D_W;
   localparam int SUM_W   = SQ_W + 1;
   localparam int ISQ_RAW = (SUM_W + 1) / 2 * 2;
   localparam int ISQ_W   = (NORM_SQ_TOP + 2 > ISQ_RAW) ? NORM_SQ_TOP + 2 : ISQ_RAW;
   localparam int ROOT_W  = ISQ_W / 2;
   localparam int Z_W     = (NORM_Z_TOP + 2 > D_W) ? NORM_Z_TOP + 2 : D_W;
   localparam int C_TMP   = (Z_W > ROOT_W + 1) ? Z_W : ROOT_W + 1;
   localparam int C_IN_W  = (C_TMP > D_W) ? C_TMP : D_W;
   localparam int K_W     = $clog2(NORM_MAX_SHIFT + 1);
   localparam int RNG_W   = COORD_WIDTH + 1;
   localparam int CL      = CORDIC_STAGES + 4;
   localparam int LAT     = 5 + ROOT_W + CL;

   logic signed [COORD_WIDTH-1:0] ref_x_ff, ref_y_ff, ref_z_ff;
   logic [LAT-1:0]                vld_ff;
   logic                          adv;

   logic signed [D_W-1:0] dx1_ff, dy1_ff, dz1_ff, dx1_in, dy1_in, dz1_in;
   logic [SQ_W-1:0]       sqx2_ff, sqy2_ff, sqz2_ff, sqx2_in, sqy2_in, sqz2_in;
   logic [D_W-1:0]        az2_ff, az2_in, az3_ff;
   logic signed [D_W-1:0] dz2_ff, dz3_ff, dz4_ff;
   logic [SUM_W-1:0]      sxy3_ff, s33_ff, sxy3_in, s33_in, sxy4_ff, s34_ff;
   logic [K_W-1:0]        k4_ff, k4_in;
   logic [ISQ_W-1:0]      sh5_ff, sxy5_ff, s35_ff;
   logic signed [Z_W-1:0] z5_ff;

   logic [ROOT_W-1:0]       root3, rootxy, rootr;
   logic [Z_W-1:0]          z_dly;
   logic [2*D_W-1:0]        dxy_dly;
   logic signed [D_W-1:0]   dx_d, dy_d;
   logic [2*RNG_W-1:0]      rng_dly;
   logic signed [C_IN_W-1:0] inc_y, inc_x, brg_y, brg_x;
   logic [ANGLE_WIDTH-1:0]  brg_ang, inc_ang;

   logic                          rsp_valid_ff;
   logic [RNG_W-1:0]              range3_ff, rangexy_ff;
   logic signed [ANGLE_WIDTH-1:0] bearing_ff, incl_ff;

   // advance when the output register is free or the last stage is empty
   assign adv           = !rsp_valid_ff || rsp_bus.ready || !vld_ff[LAT-1];
   assign req_bus.ready = adv;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff <= '0;
         ref_y_ff <= '0;
         ref_z_ff <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_REF_X: ref_x_ff <= csr_bus.data;
            CSR_REF_Y: ref_y_ff <= csr_bus.data;
            CSR_REF_Z: ref_z_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      dx1_in = D_W'(ref_x_ff) - D_W'(req_bus.target_x);
      dy1_in = D_W'(ref_y_ff) - D_W'(req_bus.target_y);
      dz1_in = D_W'(req_bus.target_z) - D_W'(ref_z_ff);
   end

   always_comb begin
      logic [D_W-1:0] ax, ay;
      ax      = dx1_ff[D_W-1] ? D_W'(-dx1_ff) : D_W'(dx1_ff);
      ay      = dy1_ff[D_W-1] ? D_W'(-dy1_ff) : D_W'(dy1_ff);
      az2_in  = dz1_ff[D_W-1] ? D_W'(-dz1_ff) : D_W'(dz1_ff);
      sqx2_in = SQ_W'(ax) * SQ_W'(ax);
      sqy2_in = SQ_W'(ay) * SQ_W'(ay);
      sqz2_in = SQ_W'(az2_in) * SQ_W'(az2_in);
   end

   always_comb begin
      sxy3_in = SUM_W'(sqx2_ff) + SUM_W'(sqy2_ff);
      s33_in  = sxy3_in + SUM_W'(sqz2_ff);
   end

   // scale so the inclination vector keeps about 30 significant bits
   always_comb begin
      k4_in = '0;
      for (int i = 0; i < NORM_MAX_SHIFT; i++) begin
         if (((sxy3_ff >> (NORM_SQ_TOP - 2 * i)) == '0) &&
             ((az3_ff >> (NORM_Z_TOP - i)) == '0)) begin
            k4_in = K_W'(i + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx1_ff  <= dx1_in;
         dy1_ff  <= dy1_in;
         dz1_ff  <= dz1_in;
         sqx2_ff <= sqx2_in;
         sqy2_ff <= sqy2_in;
         sqz2_ff <= sqz2_in;
         az2_ff  <= az2_in;
         dz2_ff  <= dz1_ff;
         sxy3_ff <= sxy3_in;
         s33_ff  <= s33_in;
         az3_ff  <= az2_ff;
         dz3_ff  <= dz2_ff;
         k4_ff   <= k4_in;
         sxy4_ff <= sxy3_ff;
         s34_ff  <= s33_ff;
         dz4_ff  <= dz3_ff;
         sh5_ff  <= ISQ_W'(sxy4_ff) << {k4_ff, 1'b0};
         z5_ff   <= Z_W'(dz4_ff) <<< k4_ff;
         sxy5_ff <= ISQ_W'(sxy4_ff);
         s35_ff  <= ISQ_W'(s34_ff);
      end
   end

   rbi_isqrt #(.IN_W(ISQ_W)) u_sqrt_3d (
      .clock(clock), .enable(adv), .radicand(s35_ff), .root(root3)
   );

   rbi_isqrt #(.IN_W(ISQ_W)) u_sqrt_xy (
      .clock(clock), .enable(adv), .radicand(sxy5_ff), .root(rootxy)
   );

   rbi_isqrt #(.IN_W(ISQ_W)) u_sqrt_incl (
      .clock(clock), .enable(adv), .radicand(sh5_ff), .root(rootr)
   );

   rbi_delay #(.WIDTH(Z_W), .DEPTH(ROOT_W)) u_dly_z (
      .clock(clock), .enable(adv), .din(z5_ff), .dout(z_dly)
   );

   rbi_delay #(.WIDTH(2 * D_W), .DEPTH(4 + ROOT_W)) u_dly_dxy (
      .clock(clock), .enable(adv), .din({dx1_ff, dy1_ff}), .dout(dxy_dly)
   );

   rbi_delay #(.WIDTH(2 * RNG_W), .DEPTH(CL)) u_dly_rng (
      .clock(clock), .enable(adv),
      .din({root3[RNG_W-1:0], rootxy[RNG_W-1:0]}), .dout(rng_dly)
   );

   assign {dx_d, dy_d} = dxy_dly;
   assign inc_y = C_IN_W'($signed(z_dly));
   assign inc_x = C_IN_W'({1'b0, rootr});
   assign brg_y = C_IN_W'(dy_d);
   assign brg_x = C_IN_W'(dx_d);

   rbi_cordic #(
      .IN_W(C_IN_W), .ANGLE_WIDTH(ANGLE_WIDTH), .STAGES(CORDIC_STAGES)
   ) u_cordic_brg (
      .clock(clock), .enable(adv), .vec_y(brg_y), .vec_x(brg_x), .angle(brg_ang)
   );

   rbi_cordic #(
      .IN_W(C_IN_W), .ANGLE_WIDTH(ANGLE_WIDTH), .STAGES(CORDIC_STAGES)
   ) u_cordic_inc (
      .clock(clock), .enable(adv), .vec_y(inc_y), .vec_x(inc_x), .angle(inc_ang)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff <= {vld_ff[LAT-2:0], req_bus.valid};
         end
         if (adv && vld_ff[LAT-1]) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && vld_ff[LAT-1]) begin
         {range3_ff, rangexy_ff} <= rng_dly;
         bearing_ff              <= brg_ang;
         incl_ff                 <= inc_ang;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.range_3d    = range3_ff;
   assign rsp_bus.range_xy    = rangexy_ff;
   assign rsp_bus.bearing     = bearing_ff;
   assign rsp_bus.inclination = incl_ff;

`ifndef SYNTHESIS
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready && vld_ff[LAT-1] |-> !adv)
      else $error("pipeline advanced over a stalled result");

   a_request_enters: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && adv |=> vld_ff[0])
      else $error("accepted request lost at pipeline entry");

   a_range_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rangexy_ff <= range3_ff))
      else $error("horizontal range exceeds 3D range");
`endif

endmodule
